### src/flash_program_sequencer_core_defines.svh
// Assertion macros shared by the checker of the flash program sequencer.
`ifndef FLASH_PROGRAM_SEQUENCER_CORE_DEFINES_SVH
`define FLASH_PROGRAM_SEQUENCER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define FPSC_ASSERT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fpsc check failed");

// Next-cycle implication, sampled on clk, off while rst is high.
`define FPSC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fpsc check failed");

`endif

### src/fpsc_pkg.sv
// Types and constants of the flash program sequencer.
package fpsc_pkg;

  typedef enum logic [1:0] {
    CMD_ERASE = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_DATA  = 2'd2,
    CMD_TICK  = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ACT_ENABLE   = 3'd0,
    ACT_DISABLE  = 3'd1,
    ACT_LOAD     = 3'd2,
    ACT_ERASE    = 3'd3,
    ACT_WRITE    = 3'd4,
    ACT_FINISHED = 3'd5
  } action_t;

  typedef enum logic [1:0] {
    RC_OK      = 2'd0,
    RC_INVALID = 2'd1,
    RC_LOCKED  = 2'd2,
    RC_TIMEOUT = 2'd3
  } code_t;

  localparam logic [23:0] TIMEOUT_RESET = 24'd10000000;

  typedef struct packed {
    cmd_t        command;
    logic [31:0] address;
    logic [15:0] word_count;
    logic [31:0] data_word;
    logic        flash_busy;
    logic        data_ready;
    logic        address_invalid;
    logic        page_locked;
  } in_item_t;

  typedef struct packed {
    action_t     action;
    logic [31:0] out_address;
    logic [31:0] out_data;
    code_t       result_code;
    logic        last;
  } out_item_t;

  // All results caused by one input word, in order; cnt is 1 to 3.
  typedef struct packed {
    logic [1:0]      cnt;
    logic [2:0][2:0] act;
    logic [31:0]     address;
    logic [31:0]     data;
    code_t           code;
  } bundle_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

### src/flash_program_sequencer_core.sv
// Top level of the flash program sequencer.
//
//  channel   | handshake             | word
//  ----------+-----------------------+-------------------------------
//  input     | push / full           | in_item  (command or status tick)
//  result    | empty / pop           | out_item (one controller action)
//  config    | cfg_valid / cfg_ready | cfg_data (timeout_ticks)
//
// An input word is taken every clock while the bundle queue has room; the
// front part decides its results in the same cycle. Results leave one per
// clock from the output register while pop is high, so a word that causes
// three results holds the result side until all three are popped. Reset has
// no clearing pass. A stalled result side backs up through the queue to full.
module flash_program_sequencer_core import fpsc_pkg::*; #(
  parameter int PAGE_BYTES  = 512,
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  in_item_t    in_item,
  output logic        empty,
  input  logic        pop,
  output out_item_t   out_item,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [23:0] cfg_data
);

  logic    accept;
  logic    bnd_valid;
  bundle_t bnd;
  bundle_t head;
  q_stat_t stat;
  logic    rd_en;

  assign full      = stat.full;
  assign accept    = push && !stat.full;
  assign cfg_ready = 1'b1;

  fpsc_front #(
    .PAGE_BYTES(PAGE_BYTES)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .in_item  (in_item),
    .cfg_valid(cfg_valid),
    .cfg_data (cfg_data),
    .bnd_valid(bnd_valid),
    .bnd      (bnd)
  );

  fpsc_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (accept && bnd_valid),
    .wr_data(bnd),
    .rd_en  (rd_en),
    .rd_data(head),
    .stat   (stat)
  );

  fpsc_back u_back (
    .clk     (clk),
    .rst     (rst),
    .head    (head),
    .stat    (stat),
    .pop     (pop),
    .rd_en   (rd_en),
    .empty   (empty),
    .out_item(out_item)
  );

endmodule

### src/fpsc_front.sv
// Front part: accepts commands and status ticks, runs the sequence, builds result bundles.
module fpsc_front import fpsc_pkg::*; #(
  parameter int PAGE_BYTES = 512
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        accept,
  input  in_item_t    in_item,
  input  logic        cfg_valid,
  input  logic [23:0] cfg_data,
  output logic        bnd_valid,
  output bundle_t     bnd
);

  // PAGE_BYTES is a power of two from 4 to 65536
  localparam int PAGE_LSB = $clog2(PAGE_BYTES);
  localparam int SPAN_W   = PAGE_LSB + 1;

  typedef enum logic [4:0] {
    PH_IDLE       = 5'b00001,
    PH_CHECK      = 5'b00010,
    PH_AWAIT_DATA = 5'b00100,
    PH_WAIT_READY = 5'b01000,
    PH_WAIT_BUSY  = 5'b10000
  } phase_t;

  phase_t      phase, phase_next;
  logic        is_erase, is_erase_next;
  logic [23:0] wait_timer, wait_timer_next;
  logic [31:0] next_address, next_address_next;
  logic [15:0] words_left, words_left_next;
  logic [15:0] page_words_left, page_words_left_next;
  logic [31:0] held_word;
  logic        held_load;
  logic [23:0] timeout_ticks;
  logic [31:0] addr_inc;
  logic [15:0] words_dec;
  logic [15:0] page_dec;

  // Words left in the page from addr on, at least one, at most left.
  function automatic logic [15:0] page_words(input logic [31:0] addr,
                                             input logic [15:0] left);
    logic [SPAN_W-1:0] span;
    logic [15:0]       pw;
    span = SPAN_W'(PAGE_BYTES) - SPAN_W'(addr[PAGE_LSB-1:0]);
    pw   = 16'(span >> 2);
    if (pw == 16'd0) pw = 16'd1;
    if (pw > left) pw = left;
    return pw;
  endfunction

  assign addr_inc  = next_address + 32'd4;
  assign words_dec = words_left - 16'd1;
  assign page_dec  = page_words_left - 16'd1;

  always_comb begin
    phase_next           = phase;
    is_erase_next        = is_erase;
    wait_timer_next      = wait_timer;
    next_address_next    = next_address;
    words_left_next      = words_left;
    page_words_left_next = page_words_left;
    held_load            = 1'b0;
    bnd_valid            = 1'b0;
    bnd                  = '0;
    unique case (phase)
      PH_IDLE: begin
        if (in_item.command == CMD_ERASE) begin
          is_erase_next     = 1'b1;
          next_address_next = in_item.address;
          bnd_valid         = 1'b1;
          bnd.cnt           = 2'd2;
          bnd.act[0]        = ACT_ENABLE;
          bnd.act[1]        = ACT_LOAD;
          bnd.address       = in_item.address;
          phase_next        = PH_CHECK;
        end else if (in_item.command == CMD_WRITE) begin
          is_erase_next     = 1'b0;
          next_address_next = in_item.address;
          words_left_next   = in_item.word_count;
          bnd_valid         = 1'b1;
          bnd.act[0]        = ACT_ENABLE;
          if (in_item.word_count == 16'd0) begin
            bnd.cnt    = 2'd3;
            bnd.act[1] = ACT_DISABLE;
            bnd.act[2] = ACT_FINISHED;
            bnd.code   = RC_OK;
          end else begin
            page_words_left_next = page_words(in_item.address, in_item.word_count);
            bnd.cnt     = 2'd2;
            bnd.act[1]  = ACT_LOAD;
            bnd.address = in_item.address;
            phase_next  = PH_CHECK;
          end
        end
      end
      PH_CHECK: begin
        if (in_item.command == CMD_TICK) begin
          bnd_valid = 1'b1;
          if (in_item.address_invalid || in_item.page_locked) begin
            bnd.cnt    = 2'd2;
            bnd.act[0] = ACT_DISABLE;
            bnd.act[1] = ACT_FINISHED;
            bnd.code   = in_item.address_invalid ? RC_INVALID : RC_LOCKED;
            phase_next = PH_IDLE;
          end else if (is_erase) begin
            bnd.cnt         = 2'd1;
            bnd.act[0]      = ACT_ERASE;
            wait_timer_next = timeout_ticks;
            phase_next      = PH_WAIT_BUSY;
          end else begin
            bnd_valid  = 1'b0;
            phase_next = PH_AWAIT_DATA;
          end
        end
      end
      PH_AWAIT_DATA: begin
        if (in_item.command == CMD_DATA) begin
          held_load       = 1'b1;
          wait_timer_next = timeout_ticks;
          phase_next      = PH_WAIT_READY;
        end
      end
      PH_WAIT_READY: begin
        if (in_item.command == CMD_TICK) begin
          if (in_item.data_ready) begin
            bnd_valid       = 1'b1;
            bnd.cnt         = 2'd1;
            bnd.act[0]      = ACT_WRITE;
            bnd.data        = held_word;
            wait_timer_next = timeout_ticks;
            phase_next      = PH_WAIT_BUSY;
          end else if (wait_timer <= 24'd1) begin
            wait_timer_next = '0;
            bnd_valid       = 1'b1;
            bnd.cnt         = 2'd2;
            bnd.act[0]      = ACT_DISABLE;
            bnd.act[1]      = ACT_FINISHED;
            bnd.code        = RC_TIMEOUT;
            phase_next      = PH_IDLE;
          end else begin
            wait_timer_next = wait_timer - 24'd1;
          end
        end
      end
      PH_WAIT_BUSY: begin
        if (in_item.command == CMD_TICK) begin
          if (in_item.flash_busy) begin
            if (wait_timer <= 24'd1) begin
              wait_timer_next = '0;
              bnd_valid       = 1'b1;
              bnd.cnt         = 2'd2;
              bnd.act[0]      = ACT_DISABLE;
              bnd.act[1]      = ACT_FINISHED;
              bnd.code        = RC_TIMEOUT;
              phase_next      = PH_IDLE;
            end else begin
              wait_timer_next = wait_timer - 24'd1;
            end
          end else if (is_erase) begin
            bnd_valid  = 1'b1;
            bnd.cnt    = 2'd2;
            bnd.act[0] = ACT_DISABLE;
            bnd.act[1] = ACT_FINISHED;
            bnd.code   = RC_OK;
            phase_next = PH_IDLE;
          end else begin
            words_left_next      = words_dec;
            page_words_left_next = page_dec;
            next_address_next    = addr_inc;
            if (words_dec == 16'd0) begin
              bnd_valid  = 1'b1;
              bnd.cnt    = 2'd2;
              bnd.act[0] = ACT_DISABLE;
              bnd.act[1] = ACT_FINISHED;
              bnd.code   = RC_OK;
              phase_next = PH_IDLE;
            end else if (page_dec == 16'd0) begin
              // page boundary: reload the address and check it again
              page_words_left_next = page_words(addr_inc, words_dec);
              bnd_valid   = 1'b1;
              bnd.cnt     = 2'd1;
              bnd.act[0]  = ACT_LOAD;
              bnd.address = addr_inc;
              phase_next  = PH_CHECK;
            end else begin
              phase_next = PH_AWAIT_DATA;
            end
          end
        end
      end
      default: begin
        phase_next = PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_IDLE;
      is_erase        <= 1'b0;
      wait_timer      <= '0;
      next_address    <= '0;
      words_left      <= '0;
      page_words_left <= '0;
      timeout_ticks   <= TIMEOUT_RESET;
    end else begin
      if (cfg_valid) begin
        timeout_ticks <= cfg_data;
      end
      if (accept) begin
        phase           <= phase_next;
        is_erase        <= is_erase_next;
        wait_timer      <= wait_timer_next;
        next_address    <= next_address_next;
        words_left      <= words_left_next;
        page_words_left <= page_words_left_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && held_load) begin
      held_word <= in_item.data_word;
    end
  end

endmodule

### src/fpsc_queue.sv
// Short bundle queue between the front and back parts.
module fpsc_queue import fpsc_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    wr_en,
  input  bundle_t wr_data,
  input  logic    rd_en,
  output bundle_t rd_data,
  output q_stat_t stat
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  bundle_t         slots [DEPTH];
  logic [PW-1:0]   wr_ptr, rd_ptr;
  logic [CW-1:0]   count;

  assign stat.full  = (count == CW'(DEPTH));
  assign stat.empty = (count == '0);
  assign rd_data    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (wr_en && !rd_en) begin
        count <= count + CW'(1);
      end else if (rd_en && !wr_en) begin
        count <= count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wr_ptr] <= wr_data;
    end
  end

endmodule

### src/fpsc_back.sv
// Back part: splits each bundle into single results and holds them in the output register.
module fpsc_back import fpsc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  bundle_t   head,
  input  q_stat_t   stat,
  input  logic      pop,
  output logic      rd_en,
  output logic      empty,
  output out_item_t out_item
);

  logic      out_valid;
  logic [1:0] idx;
  logic      load;
  logic      head_last;
  action_t   act;
  out_item_t built;

  assign load      = !out_valid || pop;
  assign head_last = (idx == head.cnt - 2'd1);
  assign rd_en     = load && !stat.empty && head_last;
  assign empty     = !out_valid;
  assign act       = action_t'(head.act[idx]);

  always_comb begin
    built.action      = act;
    built.out_address = (act == ACT_LOAD) ? head.address : '0;
    built.out_data    = (act == ACT_WRITE) ? head.data : '0;
    built.result_code = (act == ACT_FINISHED) ? head.code : RC_OK;
    built.last        = head_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else if (load) begin
      out_valid <= !stat.empty;
      if (!stat.empty) begin
        // advance within the bundle, drop it after its last result
        idx <= head_last ? 2'd0 : idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && !stat.empty) begin
      out_item <= built;
    end
  end

endmodule

### src/fpsc_checker.sv
// Port-level checks of the flash program sequencer, bound to the top level.
`include "flash_program_sequencer_core_defines.svh"

module fpsc_checker import fpsc_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      empty,
  input logic      pop,
  input out_item_t out_item
);

  // a waiting result that is not taken stays put
  `FPSC_ASSERT_NEXT(a_hold, !empty && !pop, !empty && $stable(out_item))

  // a finished result always closes the results of its input word
  `FPSC_ASSERT(a_fin_last, !empty && out_item.action == ACT_FINISHED, out_item.last)

  `FPSC_ASSERT(a_addr_load, !empty && out_item.action != ACT_LOAD, out_item.out_address == '0)

  `FPSC_ASSERT(a_code_fin, !empty && out_item.action != ACT_FINISHED, out_item.result_code == RC_OK)

endmodule

bind flash_program_sequencer_core fpsc_checker u_checker (.*);

### tb/flash_program_sequencer_core_test.sv
// Self-checking testbench for the flash program sequencer: directed runs, then random runs.
module flash_program_sequencer_core_test;
  import fpsc_pkg::*;

  localparam int unsigned PAGE_BYTES = 512;
  localparam int WATCHDOG_LIMIT = 2000;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_CHECK,
    PH_AWAIT_DATA,
    PH_WAIT_READY,
    PH_WAIT_BUSY
  } seq_phase_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  in_item_t    in_item = '0;
  logic        empty;
  logic        pop = 1'b0;
  out_item_t   out_item;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [23:0] cfg_data = '0;

  // Sequencer state as predicted from accepted words.
  seq_phase_t  seq_phase = PH_IDLE;
  logic        seq_erase = 1'b0;
  logic [23:0] seq_timeout = TIMEOUT_RESET;
  logic [23:0] seq_timer = '0;
  logic [31:0] seq_addr = '0;
  logic [15:0] seq_words = '0;
  logic [15:0] seq_page_words = '0;
  logic [31:0] seq_held = '0;

  out_item_t   step_actions[$];
  out_item_t   awaited_actions[$];
  out_item_t   want;
  int          mismatches = 0;
  int          idle_cycles = 0;
  int          send_idle_pct = 0;
  int          pop_stall_pct = 0;

  flash_program_sequencer_core #(.PAGE_BYTES(PAGE_BYTES)) dut (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .in_item   (in_item),
    .empty     (empty),
    .pop       (pop),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------- predictor

  function automatic void emit_action(action_t act, logic [31:0] addr, logic [31:0] data,
                                      code_t code);
    out_item_t r;
    r.action      = act;
    r.out_address = addr;
    r.out_data    = data;
    r.result_code = code;
    r.last        = 1'b0;
    step_actions.push_back(r);
  endfunction

  function automatic void finish_run(code_t code);
    emit_action(ACT_DISABLE, '0, '0, RC_OK);
    emit_action(ACT_FINISHED, '0, '0, code);
    seq_phase = PH_IDLE;
  endfunction

  // Words left in the page at seq_addr, clamped to at least one and to the run length.
  function automatic void load_page_span();
    logic [31:0] span;
    span = (PAGE_BYTES - (seq_addr % PAGE_BYTES)) / 4;
    if (span == 0) span = 1;
    if (span > {16'd0, seq_words}) span = {16'd0, seq_words};
    seq_page_words = span[15:0];
  endfunction

  function automatic bit timer_expired();
    if (seq_timer <= 24'd1) begin
      seq_timer = '0;
      return 1'b1;
    end
    seq_timer = seq_timer - 24'd1;
    return 1'b0;
  endfunction

  // Advance the predicted sequencer by one word; return whether the word was used.
  function automatic bit sequence_step(in_item_t w);
    bit        took;
    out_item_t r;
    took = 1'b0;
    step_actions.delete();
    case (seq_phase)
      PH_IDLE: begin
        if (w.command == CMD_ERASE) begin
          took = 1'b1;
          seq_erase = 1'b1;
          seq_addr = w.address;
          emit_action(ACT_ENABLE, '0, '0, RC_OK);
          emit_action(ACT_LOAD, w.address, '0, RC_OK);
          seq_phase = PH_CHECK;
        end else if (w.command == CMD_WRITE) begin
          took = 1'b1;
          seq_erase = 1'b0;
          seq_addr = w.address;
          seq_words = w.word_count;
          emit_action(ACT_ENABLE, '0, '0, RC_OK);
          if (w.word_count == 16'd0) begin
            finish_run(RC_OK);
          end else begin
            load_page_span();
            emit_action(ACT_LOAD, w.address, '0, RC_OK);
            seq_phase = PH_CHECK;
          end
        end
      end
      PH_CHECK: begin
        if (w.command == CMD_TICK) begin
          took = 1'b1;
          if (w.address_invalid) begin
            finish_run(RC_INVALID);
          end else if (w.page_locked) begin
            finish_run(RC_LOCKED);
          end else if (seq_erase) begin
            emit_action(ACT_ERASE, '0, '0, RC_OK);
            seq_timer = seq_timeout;
            seq_phase = PH_WAIT_BUSY;
          end else begin
            seq_phase = PH_AWAIT_DATA;
          end
        end
      end
      PH_AWAIT_DATA: begin
        if (w.command == CMD_DATA) begin
          took = 1'b1;
          seq_held = w.data_word;
          seq_timer = seq_timeout;
          seq_phase = PH_WAIT_READY;
        end
      end
      PH_WAIT_READY: begin
        if (w.command == CMD_TICK) begin
          took = 1'b1;
          if (w.data_ready) begin
            emit_action(ACT_WRITE, '0, seq_held, RC_OK);
            seq_timer = seq_timeout;
            seq_phase = PH_WAIT_BUSY;
          end else if (timer_expired()) begin
            finish_run(RC_TIMEOUT);
          end
        end
      end
      PH_WAIT_BUSY: begin
        if (w.command == CMD_TICK) begin
          took = 1'b1;
          if (w.flash_busy) begin
            if (timer_expired()) finish_run(RC_TIMEOUT);
          end else if (seq_erase) begin
            finish_run(RC_OK);
          end else begin
            seq_words = seq_words - 16'd1;
            seq_page_words = seq_page_words - 16'd1;
            seq_addr = seq_addr + 32'd4;
            if (seq_words == 16'd0) begin
              finish_run(RC_OK);
            end else if (seq_page_words == 16'd0) begin
              // crossed into the next page: reload and recheck the address
              load_page_span();
              emit_action(ACT_LOAD, seq_addr, '0, RC_OK);
              seq_phase = PH_CHECK;
            end else begin
              seq_phase = PH_AWAIT_DATA;
            end
          end
        end
      end
      default: seq_phase = PH_IDLE;
    endcase
    if (step_actions.size() > 0) begin
      r = step_actions.pop_back();
      r.last = 1'b1;
      step_actions.push_back(r);
    end
    foreach (step_actions[i]) awaited_actions.push_back(step_actions[i]);
    return took;
  endfunction

  // ---------------------------------------------------------------- driving

  function automatic in_item_t build_word(cmd_t cmd, logic [31:0] addr, logic [15:0] count,
                                          logic [31:0] data, logic busy, logic ready,
                                          logic invalid, logic locked);
    in_item_t w;
    w.command         = cmd;
    w.address         = addr;
    w.word_count      = count;
    w.data_word       = data;
    w.flash_busy      = busy;
    w.data_ready      = ready;
    w.address_invalid = invalid;
    w.page_locked     = locked;
    return w;
  endfunction

  task automatic send_word(input in_item_t w, output bit took);
    if ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    push <= 1'b1;
    in_item <= w;
    @(posedge clk);
    while (full) @(posedge clk);
    took = sequence_step(w);
  endtask

  task automatic send(input in_item_t w);
    bit took;
    send_word(w, took);
  endtask

  task automatic wait_idle();
    push <= 1'b0;
    while (awaited_actions.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_timeout(input logic [23:0] ticks);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data <= ticks;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    seq_timeout = ticks;
  endtask

  // Drive the open run to its end: abort at a check, otherwise run the wait out.
  task automatic finish_open_run();
    while (seq_phase != PH_IDLE) begin
      case (seq_phase)
        PH_CHECK:
          send(build_word(CMD_TICK, $urandom, 16'($urandom), $urandom, 0, 0, 1, 0));
        PH_AWAIT_DATA:
          send(build_word(CMD_DATA, $urandom, 16'($urandom), $urandom, 0, 0, 0, 0));
        PH_WAIT_READY:
          send(build_word(CMD_TICK, $urandom, 16'($urandom), $urandom, 0, 0, 0, 0));
        default:
          send(build_word(CMD_TICK, $urandom, 16'($urandom), $urandom, 1, 0, 0, 0));
      endcase
    end
  endtask

  // Mostly the word the current phase wants, with random content; some noise.
  function automatic in_item_t next_stimulus();
    in_item_t w;
    int       pick;
    w = build_word(cmd_t'($urandom_range(3)), $urandom, 16'($urandom), $urandom,
                   1'($urandom_range(1)), 1'($urandom_range(1)),
                   1'($urandom_range(1)), 1'($urandom_range(1)));
    if ($urandom_range(99) < 10) return w;
    w.address_invalid = 1'b0;
    w.page_locked = 1'b0;
    case (seq_phase)
      PH_IDLE: begin
        w.command = $urandom_range(1) ? CMD_WRITE : CMD_ERASE;
        if ($urandom_range(1)) w.address[8:0] = 9'h1f0 + 9'($urandom_range(15));
        pick = $urandom_range(99);
        if (pick < 5) w.word_count = 16'd0;
        else if (pick < 85) w.word_count = 16'($urandom_range(1, 6));
      end
      PH_CHECK: begin
        w.command = CMD_TICK;
        w.address_invalid = ($urandom_range(99) < 8);
        w.page_locked = ($urandom_range(99) < 8);
      end
      PH_AWAIT_DATA: w.command = CMD_DATA;
      PH_WAIT_READY: begin
        w.command = CMD_TICK;
        w.data_ready = ($urandom_range(99) < 70);
      end
      default: begin
        w.command = CMD_TICK;
        w.flash_busy = ($urandom_range(99) < 40);
      end
    endcase
    return w;
  endfunction

  always @(posedge clk) begin
    pop <= ($urandom_range(99) >= pop_stall_pct);
  end

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] exp_val);
    $display("%0t mismatch %s: got %0h, expected %0h", $realtime, what, got, exp_val);
    mismatches++;
  endtask

  always @(posedge clk) begin
    if (!rst && pop && !empty) begin
      if (awaited_actions.size() == 0) begin
        report_mismatch("unexpected result word, action", 32'(out_item.action), '0);
      end else begin
        want = awaited_actions.pop_front();
        if (out_item.action !== want.action)
          report_mismatch("action", 32'(out_item.action), 32'(want.action));
        if (out_item.out_address !== want.out_address)
          report_mismatch("out_address", out_item.out_address, want.out_address);
        if (out_item.out_data !== want.out_data)
          report_mismatch("out_data", out_item.out_data, want.out_data);
        if (out_item.result_code !== want.result_code)
          report_mismatch("result_code", 32'(out_item.result_code), 32'(want.result_code));
        if (out_item.last !== want.last)
          report_mismatch("last", 32'(out_item.last), 32'(want.last));
      end
    end
  end

  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------- tests

  task automatic test_erase_page();
    send(build_word(CMD_ERASE, 32'hffff_ffff, 16'hffff, 32'hffff_ffff, 1, 1, 0, 0));
    send(build_word(CMD_TICK, '0, '0, '0, 0, 0, 0, 0));
    send(build_word(CMD_TICK, '0, '0, '0, 1, 0, 0, 0));
    send(build_word(CMD_TICK, '0, '0, '0, 0, 1, 0, 0));
  endtask

  task automatic test_empty_write_and_strays();
    send(build_word(CMD_WRITE, 32'h0000_0000, 16'd0, '0, 0, 0, 0, 0));
    // nothing is running: drop both
    send(build_word(CMD_DATA, '0, '0, 32'hdead_beef, 0, 0, 0, 0));
    send(build_word(CMD_TICK, '0, '0, '0, 1, 1, 1, 1));
  endtask

  task automatic test_status_errors();
    send(build_word(CMD_ERASE, 32'h0000_0200, '0, '0, 0, 0, 0, 0));
    send(build_word(CMD_TICK, '0, '0, '0, 0, 0, 1, 1));
    send(build_word(CMD_WRITE, 32'h0000_0000, 16'hffff, '0, 0, 0, 0, 0));
    send(build_word(CMD_TICK, '0, '0, '0, 0, 0, 0, 1));
  endtask

  // Misaligned start at the top of memory: one word, then wrap into page zero.
  task automatic test_page_wrap();
    send(build_word(CMD_WRITE, 32'hffff_fffe, 16'd2, '0, 0, 0, 0, 0));
    send(build_word(CMD_TICK, '0, '0, '0, 0, 0, 0, 0));
    send(build_word(CMD_DATA, '0, '0, 32'h0000_0000, 0, 0, 0, 0));
    send(build_word(CMD_TICK, '0, '0, '0, 0, 1, 0, 0));
    send(build_word(CMD_TICK, '0, '0, '0, 0, 0, 0, 0));
    send(build_word(CMD_TICK, '0, '0, '0, 0, 0, 0, 0));
    send(build_word(CMD_DATA, '0, '0, 32'hffff_ffff, 0, 0, 0, 0));
    send(build_word(CMD_TICK, '0, '0, '0, 0, 1, 0, 0));
    send(build_word(CMD_TICK, '0, '0, '0, 0, 0, 0, 0));
  endtask

  task automatic test_timeouts();
    set_timeout(24'd1);
    send(build_word(CMD_WRITE, 32'h0000_1000, 16'd1, '0, 0, 0, 0, 0));
    send(build_word(CMD_TICK, '0, '0, '0, 0, 0, 0, 0));
    send(build_word(CMD_DATA, '0, '0, 32'h1234_5678, 0, 0, 0, 0));
    send(build_word(CMD_TICK, '0, '0, '0, 0, 0, 0, 0));
    set_timeout(24'd0);
    send(build_word(CMD_ERASE, 32'h0000_0400, '0, '0, 0, 0, 0, 0));
    send(build_word(CMD_TICK, '0, '0, '0, 0, 0, 0, 0));
    send(build_word(CMD_TICK, '0, '0, '0, 1, 0, 0, 0));
    set_timeout(24'hff_ffff);
    send(build_word(CMD_WRITE, 32'h0000_0000, 16'd1, '0, 0, 0, 0, 0));
    send(build_word(CMD_TICK, '0, '0, '0, 0, 0, 0, 0));
    send(build_word(CMD_DATA, '0, '0, 32'h8000_0001, 0, 0, 0, 0));
    send(build_word(CMD_TICK, '0, '0, '0, 0, 0, 0, 0));
    send(build_word(CMD_TICK, '0, '0, '0, 0, 1, 0, 0));
    send(build_word(CMD_TICK, '0, '0, '0, 1, 0, 0, 0));
    send(build_word(CMD_TICK, '0, '0, '0, 0, 0, 0, 0));
  endtask

  task automatic test_random_traffic(input int idle_pct, input int stall_pct, input int quota);
    int taken;
    bit took;
    taken = 0;
    finish_open_run();
    set_timeout(24'($urandom_range(1, 4)));
    send_idle_pct = idle_pct;
    pop_stall_pct = stall_pct;
    while (taken < quota) begin
      send_word(next_stimulus(), took);
      if (took) taken++;
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_erase_page();
    test_empty_write_and_strays();
    test_status_errors();
    test_page_wrap();
    test_timeouts();
    test_random_traffic(0, 0, 33);
    test_random_traffic(48, 0, 33);
    test_random_traffic(0, 48, 33);
    test_random_traffic(38, 38, 33);
    finish_open_run();
    wait_idle();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && awaited_actions.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+src
src/fpsc_pkg.sv
src/fpsc_front.sv
src/fpsc_queue.sv
src/fpsc_back.sv
src/flash_program_sequencer_core.sv
src/fpsc_checker.sv
tb/flash_program_sequencer_core_test.sv
